// ----- rtl/fts_pkg.sv -----
// ----------------------------------------------------------------------------
// fts_pkg
// shared types and constants for the frame timestamp tracker
// ----------------------------------------------------------------------------
package fts_pkg;

    localparam logic [2:0] OP_TRACK    = 3'd0;
    localparam logic [2:0] OP_RENDERED = 3'd1;
    localparam logic [2:0] OP_SEEK     = 3'd2;
    localparam logic [2:0] OP_INPUT    = 3'd3;
    localparam logic [2:0] OP_TIMEOUT  = 3'd4;
    localparam logic [2:0] OP_CLEAR    = 3'd5;
    localparam logic [2:0] OP_RSVD_A   = 3'd6;
    localparam logic [2:0] OP_RSVD_B   = 3'd7;

    localparam logic [1:0] REG_TUNNELED = 2'd0;
    localparam logic [1:0] REG_IN_THR   = 2'd1;
    localparam logic [1:0] REG_PEND_THR = 2'd2;
    localparam logic [1:0] REG_MAX_PEND = 2'd3;

    localparam logic [63:0] NONE_TIME = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;

    // datapath commands
    typedef struct packed {
        logic clear;      // empty table, reset tracking
        logic scan_rst;   // reset scan index
        logic scan_step;  // advance scan, read next entry
        logic ins_start;  // begin insertion shift from the end
        logic ins_step;   // one shift step
        logic ins_write;  // write new word at insertion point
        logic ret_start;  // begin compaction after retire
        logic ret_step;   // one compaction move
        logic ret_done;   // commit new count
        logic seek;       // latch seek time
        logic inc_input;  // bump input count
        logic drop_cnt;   // count current entry as dropped
        logic retire;     // count current entry as retired
    } t_cmd;

    typedef struct packed {
        logic scan_end;   // scan index reached count
        logic hit_dup;    // current entry equals key
        logic le_t;       // current entry at or below input time
        logic drop_cond;  // current entry counts as dropped
        logic full;       // table full
        logic ins_end;    // shift reached insertion point
        logic ret_end;    // compaction finished
        logic chk_ok;     // preroll criteria met
        logic inp_pos;    // input count nonzero
    } t_sts;

    function automatic logic [63:0] order_key(input logic [63:0] t);
        return t ^ SIGN_BIT;
    endfunction

endpackage

// ----- rtl/fts_datapath.sv -----
// ----------------------------------------------------------------------------
// fts_datapath
// timestamp memory, scan pointers, counters and compare logic
// ----------------------------------------------------------------------------
module fts_datapath import fts_pkg::*; #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [63:0] i_time,
    input  logic [7:0]  i_in_thr,
    input  logic [7:0]  i_pend_thr,
    input  logic [7:0]  i_max_pend,
    output t_sts        o_sts,
    output logic [7:0]  o_drop_now,
    output logic [31:0] o_drop_total,
    output logic [7:0]  o_pending
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [63:0]   r_mem [TABLE_DEPTH];
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_ret;
    logic [63:0]   r_rd;
    logic [63:0]   r_last;
    logic [63:0]   r_seek;
    logic [31:0]   r_inp;
    logic [31:0]   r_drop;
    logic [7:0]    r_drop_now;
    logic [CW-1:0] n_rd_addr;
    logic          n_rd_en;
    logic          n_wr_en;
    logic [CW-1:0] n_wr_addr;
    logic [63:0]   n_wr_data;

    // one read port, one write port
    always_comb begin
        n_rd_en   = 1'b0;
        n_rd_addr = r_idx;
        n_wr_en   = 1'b0;
        n_wr_addr = r_idx;
        n_wr_data = r_rd;
        if (i_cmd.scan_rst) begin
            n_rd_en   = 1'b1;
            n_rd_addr = '0;
        end else if (i_cmd.scan_step) begin
            n_rd_en   = 1'b1;
            n_rd_addr = r_idx + CW'(1);
        end else if (i_cmd.ins_start) begin
            n_rd_en   = 1'b1;
            n_rd_addr = r_cnt - CW'(1);
        end else if (i_cmd.ins_step) begin
            n_wr_en   = 1'b1;
            n_wr_addr = r_idx;
            n_rd_en   = 1'b1;
            n_rd_addr = r_idx - CW'(2);
        end else if (i_cmd.ins_write) begin
            n_wr_en   = 1'b1;
            n_wr_addr = r_idx;
            n_wr_data = i_time;
        end else if (i_cmd.ret_start) begin
            n_rd_en   = 1'b1;
            n_rd_addr = r_ret;
        end else if (i_cmd.ret_step) begin
            n_wr_en   = 1'b1;
            n_wr_addr = r_idx;
            n_rd_en   = 1'b1;
            n_rd_addr = r_ret + r_idx + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_mem[n_wr_addr[AW-1:0]] <= n_wr_data;
        end
        if (n_rd_en) begin
            r_rd <= r_mem[n_rd_addr[AW-1:0]];
        end
        if (n_wr_en && n_wr_addr == r_cnt) begin
            r_last <= n_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_idx      <= '0;
            r_ret      <= '0;
            r_seek     <= NONE_TIME;
            r_inp      <= '0;
            r_drop     <= '0;
            r_drop_now <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_cnt  <= '0;
                r_seek <= NONE_TIME;
                r_inp  <= '0;
            end
            if (i_cmd.scan_rst) begin
                r_idx      <= '0;
                r_ret      <= '0;
                r_drop_now <= '0;
            end
            if (i_cmd.scan_step) r_idx <= r_idx + CW'(1);
            if (i_cmd.retire)    r_ret <= r_ret + CW'(1);
            if (i_cmd.drop_cnt) begin
                if (r_drop_now != 8'hFF) r_drop_now <= r_drop_now + 8'd1;
                if (r_drop != 32'hFFFF_FFFF) r_drop <= r_drop + 32'd1;
            end
            if (i_cmd.ins_start) r_idx <= r_cnt;
            if (i_cmd.ins_step)  r_idx <= r_idx - CW'(1);
            if (i_cmd.ins_write) r_cnt <= r_cnt + CW'(1);
            if (i_cmd.ret_start) r_idx <= '0;
            if (i_cmd.ret_step)  r_idx <= r_idx + CW'(1);
            if (i_cmd.ret_done)  r_cnt <= r_cnt - r_ret;
            if (i_cmd.seek)      r_seek <= i_time;
            if (i_cmd.inc_input && r_inp != 32'hFFFF_FFFF) r_inp <= r_inp + 32'd1;
        end
    end

    logic [15:0] w_cnt16;
    assign w_cnt16 = 16'(r_cnt);

    always_comb begin
        o_sts           = '0;
        o_sts.scan_end  = (r_idx >= r_cnt);
        o_sts.hit_dup   = (r_rd == i_time);
        o_sts.le_t      = (order_key(r_rd) <= order_key(i_time));
        o_sts.drop_cond = (order_key(r_rd) >= order_key(r_seek)) &&
                          (order_key(r_rd) < order_key(i_time));
        o_sts.full      = (r_cnt >= CW'(TABLE_DEPTH));
        o_sts.ins_end   = (r_idx == '0) ||
                          (order_key(r_rd) <= order_key(i_time));
        o_sts.ret_end   = (r_idx >= r_cnt - r_ret);
        o_sts.inp_pos   = (r_inp != '0);
        o_sts.chk_ok    = (r_inp > 32'(i_in_thr)) &&
                          (((r_seek != NONE_TIME) && (w_cnt16 > 16'(i_pend_thr)) &&
                            (r_cnt != '0) &&
                            (order_key(r_last) >= order_key(r_seek))) ||
                           (w_cnt16 >= 16'(i_max_pend)));
    end

    assign o_drop_now   = r_drop_now;
    assign o_drop_total = r_drop;
    assign o_pending    = (w_cnt16 > 16'd255) ? 8'hFF : w_cnt16[7:0];

endmodule

// ----- rtl/fts_ctrl.sv -----
// ----------------------------------------------------------------------------
// fts_ctrl
// event sequencer driving the datapath, result strobe
// ----------------------------------------------------------------------------
module fts_ctrl import fts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [2:0] i_op,
    input  logic       i_eos,
    input  logic       i_tunneled,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       busy,
    output logic       o_valid,
    output logic       o_done,
    output logic       o_dup,
    output logic       o_ovf,
    output logic       o_prerolling,
    output logic       o_rend
);

    typedef enum logic [3:0] {
        S_IDLE, S_DSCAN, S_DWAIT, S_INS_RD, S_INS, S_REND_RD, S_REND,
        S_RET_RD, S_RET, S_CHECK, S_REPLY
    } t_state;

    t_state     r_state;
    logic [2:0] r_op;
    logic       r_eos;
    logic       r_pre;
    logic       r_done;
    logic       r_dup;
    logic       r_ovf;
    logic       r_valid;
    logic       r_rend;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_op == OP_TRACK || i_op == OP_RENDERED) o_cmd.scan_rst = 1'b1;
                    if (i_op == OP_SEEK)  o_cmd.seek = 1'b1;
                    if (i_op == OP_CLEAR) o_cmd.clear = 1'b1;
                    if (i_op == OP_INPUT && i_tunneled) o_cmd.inc_input = 1'b1;
                end
            end
            S_DSCAN: begin
                if (!i_sts.scan_end && !i_sts.hit_dup) o_cmd.scan_step = 1'b1;
                else if (i_sts.scan_end && !i_sts.full) o_cmd.ins_start = 1'b1;
            end
            S_INS: begin
                if (i_sts.ins_end) o_cmd.ins_write = 1'b1;
                else o_cmd.ins_step = 1'b1;
            end
            S_REND: begin
                if (!i_sts.scan_end && i_sts.le_t) begin
                    o_cmd.scan_step = 1'b1;
                    o_cmd.retire    = 1'b1;
                    o_cmd.drop_cnt  = i_sts.drop_cond;
                end else o_cmd.ret_start = 1'b1;
            end
            S_RET: begin
                if (i_sts.ret_end) o_cmd.ret_done = 1'b1;
                else o_cmd.ret_step = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_TRACK;
            r_eos   <= 1'b0;
            r_pre   <= 1'b0;
            r_done  <= 1'b0;
            r_dup   <= 1'b0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
            r_rend  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op   <= i_op;
                        r_eos  <= i_eos;
                        r_done <= 1'b0;
                        r_dup  <= 1'b0;
                        r_ovf  <= 1'b0;
                        r_rend <= (i_op == OP_RENDERED);
                        priority case (i_op)
                            OP_TRACK:    r_state <= S_DWAIT;
                            OP_RENDERED: r_state <= S_REND_RD;
                            OP_SEEK: begin
                                if (i_tunneled) r_pre <= 1'b1;
                                r_state <= S_CHECK;
                            end
                            OP_INPUT:    r_state <= S_CHECK;
                            OP_TIMEOUT: begin
                                if (r_pre && i_sts.inp_pos) begin
                                    r_pre  <= 1'b0;
                                    r_done <= 1'b1;
                                end
                                r_state <= S_REPLY;
                            end
                            OP_CLEAR: begin
                                r_pre   <= 1'b0;
                                r_state <= S_REPLY;
                            end
                            default:     r_state <= S_REPLY;
                        endcase
                    end
                end
                S_DWAIT: r_state <= S_DSCAN;
                S_DSCAN: begin
                    if (!i_sts.scan_end && i_sts.hit_dup) begin
                        r_dup   <= 1'b1;
                        r_state <= S_CHECK;
                    end else if (!i_sts.scan_end) r_state <= S_DWAIT;
                    else if (i_sts.full) begin
                        r_ovf   <= 1'b1;
                        r_state <= S_CHECK;
                    end else r_state <= S_INS_RD;
                end
                S_INS_RD: r_state <= S_INS;
                S_INS: begin
                    if (i_sts.ins_end) r_state <= S_CHECK;
                end
                S_REND_RD: r_state <= S_REND;
                S_REND: begin
                    if (!i_sts.scan_end && i_sts.le_t) r_state <= S_REND_RD;
                    else r_state <= S_RET_RD;
                end
                S_RET_RD: r_state <= S_RET;
                S_RET: begin
                    if (i_sts.ret_end) r_state <= S_REPLY;
                    else r_state <= S_RET_RD;
                end
                S_CHECK: begin
                    if (i_tunneled && r_pre && (r_op != OP_INPUT || !r_eos) &&
                        i_sts.chk_ok) begin
                        r_pre  <= 1'b0;
                        r_done <= 1'b1;
                    end else if (i_tunneled && r_pre && r_op == OP_INPUT && r_eos) begin
                        r_pre  <= 1'b0;
                        r_done <= 1'b1;
                    end
                    r_state <= S_REPLY;
                end
                S_REPLY: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_done       = r_done;
    assign o_dup        = r_dup;
    assign o_ovf        = r_ovf;
    assign o_prerolling = r_pre;
    assign o_rend       = r_rend;

endmodule

// ----- rtl/frame_timestamp_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// frame_timestamp_tracker_unit
// sorted table of pending frame timestamps with preroll tracking
// ----------------------------------------------------------------------------
// latency accept to result follows the walk: timeout, clear, unused codes go to reply;
// seek, input add a preroll check; track scans for duplicates, shifts to insert, checks;
// rendered retires, then compacts kept entries; next word accepted in the strobe cycle
// one event at a time, set by the sequential timestamp memory walk
// result strobe o_valid lasts one cycle, receiver cannot stall
// synchronous active-low reset clears control state and counters
module frame_timestamp_tracker_unit import fts_pkg::*; #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic signed [63:0] i_timestamp,
    input  logic        i_end_of_stream,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output logic        o_valid,
    output logic        o_preroll_done,
    output logic        o_duplicate_seen,
    output logic        o_table_overflow,
    output logic [7:0]  o_dropped_now,
    output logic [31:0] o_dropped_total,
    output logic [7:0]  o_pending_count,
    output logic        o_prerolling_flag
);

    logic        r_tun;
    logic [7:0]  r_in_thr;
    logic [7:0]  r_pend_thr;
    logic [7:0]  r_max_pend;
    logic [63:0] r_time;
    t_cmd        w_cmd;
    t_sts        w_sts;
    logic        w_rend;
    logic [7:0]  w_drop_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tun      <= 1'b1;
            r_in_thr   <= 8'd8;
            r_pend_thr <= 8'd24;
            r_max_pend <= 8'd128;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TUNNELED: r_tun      <= i_cfg_data[0];
                REG_IN_THR:   r_in_thr   <= i_cfg_data;
                REG_PEND_THR: r_pend_thr <= i_cfg_data;
                REG_MAX_PEND: r_max_pend <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) r_time <= i_timestamp;
    end

    logic [63:0] w_time;
    assign w_time = (start && !busy) ? i_timestamp : r_time;

    fts_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_op         (i_opcode),
        .i_eos        (i_end_of_stream),
        .i_tunneled   (r_tun),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd),
        .busy         (busy),
        .o_valid      (o_valid),
        .o_done       (o_preroll_done),
        .o_dup        (o_duplicate_seen),
        .o_ovf        (o_table_overflow),
        .o_prerolling (o_prerolling_flag),
        .o_rend       (w_rend)
    );

    fts_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_time       (w_time),
        .i_in_thr     (r_in_thr),
        .i_pend_thr   (r_pend_thr),
        .i_max_pend   (r_max_pend),
        .o_sts        (w_sts),
        .o_drop_now   (w_drop_now),
        .o_drop_total (o_dropped_total),
        .o_pending    (o_pending_count)
    );

    assign o_dropped_now = w_rend ? w_drop_now : 8'd0;

    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_duplicate_seen && o_table_overflow))
        else $error("duplicate and overflow together");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_preroll_done) |-> !o_prerolling_flag)
        else $error("preroll done while still prerolling");

endmodule
